FILE: src/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-ascii mapping
// for the base64 stream encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CODES_PER_CMD = 4;
	localparam int unsigned CNT_W = $clog2(CODES_PER_CMD);
	localparam logic [7:0] PAD_ASCII = 8'h3D;

	// position within the current three-byte group
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} code_t;

	// one request's worth of characters
	typedef struct packed {
		code_t [CODES_PER_CMD-1:0] codes;
		logic [CNT_W-1:0]          last_idx;
		logic                      last;
		logic                      url;
	} cmd_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h47 + {2'b00, v};
		end else if (v < 6'd62) begin
			c = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			c = url ? 8'h2D : 8'h2B;
		end else begin
			c = url ? 8'h5F : 8'h2F;
		end
		return c;
	endfunction

	function automatic logic [7:0] code_char(input code_t code, input logic url);
		logic [7:0] c;
		c = code.pad ? PAD_ASCII : sextet_char(code.sextet, url);
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/b64e_front.sv
// b64e_front: accepts message bytes, tracks group phase and carry bits,
// and builds a character command per byte; uses b64e_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64e_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic           cfg_wr_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     data_byte,
	input  wire logic           last_byte,
	input  wire logic           q_full,
	output logic                push,
	output b64e_pkg::cmd_t      push_cmd
);
	import b64e_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] carry_q, carry_d;
	logic       url_q;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
		end else if (cfg_wr_en) begin
			url_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			carry_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	// next state
	always_comb begin
		phase_d = PH_START;
		carry_d = '0;
		case (phase_q)
			PH_ONE: begin
				if (!last_byte) begin
					phase_d = PH_TWO;
					carry_d = data_byte[3:0];
				end
			end
			PH_TWO: begin
				phase_d = PH_START;
			end
			default: begin
				if (!last_byte) begin
					phase_d = PH_ONE;
					carry_d = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	// command built from the byte
	always_comb begin
		push_cmd      = '0;
		push_cmd.last = last_byte;
		push_cmd.url  = url_q;
		case (phase_q)
			PH_ONE: begin
				push_cmd.codes[0].sextet = {carry_q[1:0], data_byte[7:4]};
				if (last_byte) begin
					push_cmd.codes[1].sextet = {data_byte[3:0], 2'b00};
					push_cmd.codes[2].pad    = 1'b1;
					push_cmd.last_idx        = CNT_W'(2);
				end
			end
			PH_TWO: begin
				push_cmd.codes[0].sextet = {carry_q, data_byte[7:6]};
				push_cmd.codes[1].sextet = data_byte[5:0];
				push_cmd.last_idx        = CNT_W'(1);
			end
			default: begin
				push_cmd.codes[0].sextet = data_byte[7:2];
				if (last_byte) begin
					push_cmd.codes[1].sextet = {data_byte[1:0], 4'b0000};
					push_cmd.codes[2].pad    = 1'b1;
					push_cmd.codes[3].pad    = 1'b1;
					push_cmd.last_idx        = CNT_W'(3);
				end
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/b64e_queue.sv
// b64e_queue: small first-in first-out queue of character commands
// between the front and back parts; uses b64e_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64e_queue #(
	parameter int unsigned Depth = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64e_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output b64e_pkg::cmd_t       head_cmd
);
	import b64e_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/b64e_back.sv
// b64e_back: steps through the codes of each command and drives one ascii
// character per cycle while a command waits and out_ready allows, through an output register; uses b64e_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64e_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_not_empty,
	input  wire b64e_pkg::cmd_t  q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_char,
	output logic                 last_char
);
	import b64e_pkg::*;

	cmd_t             cmd_q;
	logic             cmd_valid_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             load;
	logic             cmd_done;

	assign load     = cmd_valid_q && (!out_valid_q || out_ready);
	assign cmd_done = load && (idx_q == cmd_q.last_idx);
	assign q_pop    = q_not_empty && (!cmd_valid_q || cmd_done);

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (load) begin
			char_q <= code_char(cmd_q.codes[idx_q], cmd_q.url);
			last_q <= cmd_q.last && (idx_q == cmd_q.last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cmd_valid_q <= 1'b1;
			end else if (cmd_done) begin
				cmd_valid_q <= 1'b0;
			end
			if (cmd_done || !cmd_valid_q) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/base64_stream_encoder_core.sv
// base64_stream_encoder_core: top level of the streaming base64 encoder
// built from b64e_front, b64e_queue and b64e_back; uses b64e_pkg
//
// usage:
//   input channel in_valid/in_ready carries one message byte (data_byte)
//   with last_byte set on the final byte of a message
//   output channel out_valid/out_ready carries one ascii character
//   (out_char) with last_char set on the final character or pad
//   cfg_wr_en/cfg_wr_data writes url_alphabet (1 = '-' and '_') while idle
// path: a byte's command is written into the queue, popped into the back
//   part's command register, and its characters leave through the output register
// throughput: one character per cycle while out_ready holds and commands
//   wait, set by the single output register; a group of three bytes gives
//   four characters, and a closing byte up to four characters and pads
// reset: phase, carry and alphabet clear, queue and output register empty
// receiver stall: the output register holds its character; the command
//   queue keeps taking bytes until it is full, then in_ready drops
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder_core #(
	parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            last_char
);
	import b64e_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, q_full, q_pop, q_not_empty;

	b64e_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	b64e_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (head_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_char   (last_char)
	);

endmodule
`default_nettype wire
